// File: rtl/core/lphm_pkg.sv
// Package for the linear-probe hash map unit: controller states, opcodes,
// status codes and hash shift amounts. No dependencies.
`default_nettype none

package lphm_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PROBE,
        ST_FINISH,
        ST_CLEAR
    } state_t;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ENTER  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int HASH_SHIFT_A = 10;
    localparam int HASH_SHIFT_B = 20;

endpackage

`default_nettype wire

// File: rtl/core/linear_probe_hash_map_unit.sv
// Linear-probe hash map unit, top level: slot memory, probe controller and result register.
// Depends on lphm_pkg.
// Lookup or enter probes one slot per cycle, set by the single read port of the slot memory;
// clear sweeps every slot to unused before its result is given.
// Throughput: one item at a time; a new item is accepted while a result waits on m_.
// Reset: a sweep marks every slot unused; no item is accepted meanwhile.
`default_nettype none

module linear_probe_hash_map_unit #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    localparam int IDX_BITS   = $clog2(TABLE_SLOTS),
    localparam int CNT_BITS   = $clog2(TABLE_SLOTS + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_opcode,
    input  wire logic [KEY_BITS-1:0]   s_key_id,
    input  wire logic [VALUE_BITS-1:0] s_entry_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_found,
    output logic [VALUE_BITS-1:0]      m_read_value,
    output logic                       m_status,
    output logic [CNT_BITS-1:0]        m_live_count,
    output logic                       m_half_full
);

    localparam int WORD_BITS = 1 + KEY_BITS + VALUE_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = {IDX_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] HALF_CNT = CNT_BITS'(TABLE_SLOTS / 2);

    logic [WORD_BITS-1:0] slot_mem [TABLE_SLOTS];

    lphm_pkg::state_t      state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IDX_BITS-1:0]   issue_addr_reg, issue_addr_next;
    logic [IDX_BITS-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [IDX_BITS-1:0]   chk_cnt_reg, chk_cnt_next;
    logic                  free_vld_reg, free_vld_next;
    logic [IDX_BITS-1:0]   free_addr_reg, free_addr_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_BITS-1:0]   rd_addr_reg, rd_addr_next;
    logic [WORD_BITS-1:0]  slot_rd_reg;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  res_found_reg, res_found_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                  out_status_reg, out_status_next;
    logic [CNT_BITS-1:0]   out_count_reg, out_count_next;
    logic                  out_half_reg, out_half_next;

    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [WORD_BITS-1:0]  wr_data;

    logic [KEY_BITS-1:0]   hash_sum;
    logic                  rd_used;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  key_eq, val_zero, hit, cand_free, probe_end;
    logic                  tgt_vld, tgt_live;
    logic [IDX_BITS-1:0]   tgt_addr;

    assign hash_sum = s_key_id + (s_key_id >> lphm_pkg::HASH_SHIFT_A)
                    + (s_key_id >> lphm_pkg::HASH_SHIFT_B);

    assign rd_used   = slot_rd_reg[WORD_BITS-1];
    assign rd_key    = slot_rd_reg[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_val    = slot_rd_reg[VALUE_BITS-1:0];
    assign key_eq    = (rd_key == key_reg);
    assign val_zero  = (rd_val == '0);
    assign hit       = rd_used && key_eq;
    assign cand_free = !rd_used || (!key_eq && val_zero);
    assign probe_end = !rd_used || key_eq || (chk_cnt_reg == LAST_IDX);
    assign tgt_vld   = hit || free_vld_reg || cand_free;
    assign tgt_live  = hit && !val_zero;
    assign tgt_addr  = hit ? rd_addr_reg : (free_vld_reg ? free_addr_reg : rd_addr_reg);

    assign s_ready      = (state_reg == lphm_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_found      = out_found_reg;
    assign m_read_value = out_value_reg;
    assign m_status     = out_status_reg;
    assign m_live_count = out_count_reg;
    assign m_half_full  = out_half_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        slot_rd_reg <= slot_mem[issue_addr_reg];
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        issue_addr_next = issue_addr_reg;
        sweep_addr_next = sweep_addr_reg;
        chk_cnt_next    = chk_cnt_reg;
        free_vld_next   = free_vld_reg;
        free_addr_next  = free_addr_reg;
        rd_vld_next     = (state_reg == lphm_pkg::ST_PROBE);
        rd_addr_next    = issue_addr_reg;
        count_next      = count_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_half_next   = out_half_reg;
        wr_en           = 1'b0;
        wr_addr         = sweep_addr_reg;
        wr_data         = '0;

        unique case (state_reg)
            lphm_pkg::ST_INIT, lphm_pkg::ST_CLEAR: begin
                wr_en           = 1'b1;
                sweep_addr_next = sweep_addr_reg + IDX_BITS'(1);
                if (sweep_addr_reg == LAST_IDX) begin
                    if (state_reg == lphm_pkg::ST_INIT) begin
                        state_next = lphm_pkg::ST_IDLE;
                    end else begin
                        count_next = '0;
                        state_next = lphm_pkg::ST_FINISH;
                    end
                end
            end
            lphm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    key_next        = s_key_id;
                    val_next        = s_entry_value;
                    issue_addr_next = hash_sum[IDX_BITS-1:0];
                    chk_cnt_next    = '0;
                    free_vld_next   = 1'b0;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = lphm_pkg::STATUS_OK;
                    unique case (s_opcode)
                        lphm_pkg::OP_LOOKUP, lphm_pkg::OP_ENTER: begin
                            state_next = lphm_pkg::ST_PROBE;
                        end
                        lphm_pkg::OP_CLEAR: begin
                            sweep_addr_next = '0;
                            state_next      = lphm_pkg::ST_CLEAR;
                        end
                        default: begin
                            state_next = lphm_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            lphm_pkg::ST_PROBE: begin
                issue_addr_next = issue_addr_reg + IDX_BITS'(1);
                if (rd_vld_reg) begin
                    chk_cnt_next = chk_cnt_reg + IDX_BITS'(1);
                    if (cand_free && !free_vld_reg) begin
                        free_vld_next  = 1'b1;
                        free_addr_next = rd_addr_reg;
                    end
                    if (probe_end) begin
                        state_next = lphm_pkg::ST_FINISH;
                        if (op_reg == lphm_pkg::OP_LOOKUP) begin
                            res_found_next = hit;
                            res_value_next = hit ? rd_val : '0;
                        end else if (tgt_vld) begin
                            wr_en      = 1'b1;
                            wr_addr    = tgt_addr;
                            wr_data    = {1'b1, key_reg, val_reg};
                            count_next = count_reg + CNT_BITS'(!tgt_live)
                                       - CNT_BITS'(val_reg == '0);
                        end else begin
                            res_status_next = lphm_pkg::STATUS_FULL;
                        end
                    end
                end
            end
            lphm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_found_next  = res_found_reg;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    out_half_next   = (count_reg >= HALF_CNT);
                    state_next      = lphm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lphm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lphm_pkg::ST_INIT;
            sweep_addr_reg <= '0;
            rd_vld_reg     <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            rd_vld_reg     <= rd_vld_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        issue_addr_reg <= issue_addr_next;
        chk_cnt_reg    <= chk_cnt_next;
        free_vld_reg   <= free_vld_next;
        free_addr_reg  <= free_addr_next;
        rd_addr_reg    <= rd_addr_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_half_reg   <= out_half_next;
    end

endmodule

`default_nettype wire

// File: sim/linear_probe_hash_map_unit_tb.sv
// Testbench for linear_probe_hash_map_unit: directed, capacity and random traffic,
// each item predicted by a shadow copy of the slot table and each result checked in order.
// Depends on lphm_pkg and the linear_probe_hash_map_unit RTL.
`timescale 1ns / 100ps

module linear_probe_hash_map_unit_tb;

    localparam int SLOTS = 1024;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic        found;
        logic [31:0] read_value;
        logic        status;
        logic [10:0] live_count;
        logic        half_full;
    } map_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [31:0] s_key_id;
    logic [31:0] s_entry_value;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [31:0] m_read_value;
    logic        m_status;
    logic [10:0] m_live_count;
    logic        m_half_full;

    bit          shadow_used [SLOTS];
    bit [31:0]   shadow_key [SLOTS];
    bit [31:0]   shadow_value [SLOTS];
    int unsigned shadow_live;

    map_result_t pending_results [$];
    int unsigned mismatch_count = 0;
    bit          quiet_tail;
    int unsigned ready_stall_left;

    linear_probe_hash_map_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_key_id      (s_key_id),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_live_count  (m_live_count),
        .m_half_full   (m_half_full)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic int unsigned home_index(input bit [31:0] k);
        bit [31:0] sum;
        sum = k + (k >> lphm_pkg::HASH_SHIFT_A) + (k >> lphm_pkg::HASH_SHIFT_B);
        return sum & (SLOTS - 1);
    endfunction

    function automatic bit locate_key(input bit [31:0] k, output int unsigned slot);
        int unsigned i;
        i = home_index(k);
        slot = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!shadow_used[i])
                return 1'b0;
            if (shadow_key[i] == k) begin
                slot = i;
                return 1'b1;
            end
            i = (i + 1) & (SLOTS - 1);
        end
        return 1'b0;
    endfunction

    function automatic bit locate_free(input bit [31:0] k, output int unsigned slot);
        int unsigned i;
        i = home_index(k);
        slot = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!shadow_used[i] || shadow_value[i] == 32'h0) begin
                slot = i;
                return 1'b1;
            end
            i = (i + 1) & (SLOTS - 1);
        end
        return 1'b0;
    endfunction

    function automatic map_result_t predict_map_op(input logic [1:0] op, input bit [31:0] k,
                                                   input bit [31:0] v);
        map_result_t r;
        int unsigned slot;
        bit          ok;
        r.found      = 1'b0;
        r.read_value = 32'h0;
        r.status     = lphm_pkg::STATUS_OK;
        case (op)
            lphm_pkg::OP_LOOKUP: begin
                if (locate_key(k, slot)) begin
                    r.found      = 1'b1;
                    r.read_value = shadow_value[slot];
                end
            end
            lphm_pkg::OP_ENTER: begin
                ok = locate_key(k, slot);
                if (!ok)
                    ok = locate_free(k, slot);
                if (!ok) begin
                    r.status = lphm_pkg::STATUS_FULL;
                end else begin
                    if (!shadow_used[slot] || shadow_value[slot] == 32'h0)
                        shadow_live++;
                    if (v == 32'h0)
                        shadow_live--;
                    shadow_used[slot]  = 1'b1;
                    shadow_key[slot]   = k;
                    shadow_value[slot] = v;
                end
            end
            lphm_pkg::OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++)
                    shadow_used[i] = 1'b0;
                shadow_live = 0;
            end
            default: ;
        endcase
        r.live_count = shadow_live[10:0];
        r.half_full  = (shadow_live >= SLOTS / 2);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
        int unsigned gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_key_id      <= k;
        s_entry_value <= v;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_map_op(op, k, v));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string field, input logic [31:0] expected_v,
                               input logic [31:0] actual_v);
        if (expected_v !== actual_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field, expected_v, actual_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_stall_left <= 0;
            m_ready          <= 1'b0;
        end else if (ready_stall_left > 0) begin
            ready_stall_left <= ready_stall_left - 1;
            m_ready          <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
            ready_stall_left <= $urandom_range(0, 13);
            m_ready          <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        map_result_t exp_r;
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual live_count %0d",
                         $time, m_live_count);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("found", 32'(exp_r.found), 32'(m_found));
                check_field("read_value", exp_r.read_value, m_read_value);
                check_field("status", 32'(exp_r.status), 32'(m_status));
                check_field("live_count", 32'(exp_r.live_count), 32'(m_live_count));
                check_field("half_full", 32'(exp_r.half_full), 32'(m_half_full));
            end
        end
    end

    task automatic test_basic_ops();
        send_item(lphm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lphm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'h0000_0000, 32'h0000_0001);
        send_item(lphm_pkg::OP_ENTER, 32'h0000_0000, 32'h8000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(lphm_pkg::OP_ENTER, 32'd1023, 32'h0000_00A5);
        send_item(lphm_pkg::OP_ENTER, 32'd2046, 32'h5A5A_5A5A);
        send_item(lphm_pkg::OP_LOOKUP, 32'd2046, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'h0000_0000, 32'h0000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'h1234_5678, 32'h0000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'd3069, 32'h0000_0007);
        send_item(lphm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'd3069, 32'h0000_0000);
        send_item(OP_UNUSED, $urandom, $urandom);
        send_item(lphm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lphm_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lphm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_full_table();
        send_item(lphm_pkg::OP_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i < SLOTS; i++)
            send_item(lphm_pkg::OP_ENTER, i, $urandom | 32'h1);
        send_item(lphm_pkg::OP_ENTER, 32'd2000, 32'h0000_0005);
        send_item(lphm_pkg::OP_ENTER, 32'd5000, 32'h0000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'd4096, 32'h0000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'd1023, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'd7, 32'hFFFF_0000);
        send_item(lphm_pkg::OP_ENTER, 32'd7, 32'h0000_0000);
        send_item(lphm_pkg::OP_LOOKUP, 32'd7, 32'h0000_0000);
        send_item(lphm_pkg::OP_ENTER, 32'd3000, 32'h0000_0009);
        wait_results_drained();
        send_item(lphm_pkg::OP_CLEAR, 32'h0, 32'h0);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        logic [31:0] key_pool [48];
        logic [31:0] base;
        logic [31:0] k;
        logic [31:0] v;
        int unsigned pick;
        for (int c = 0; c < 4; c++) begin
            base = $urandom;
            for (int j = 0; j < 8; j++)
                key_pool[c * 8 + j] = base + j * 1023;
        end
        for (int j = 32; j < 48; j++)
            key_pool[j] = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                wait_results_drained();
            if (n == count - 40)
                quiet_tail = 1'b1;
            k    = key_pool[$urandom_range(0, 47)];
            v    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_item(lphm_pkg::OP_ENTER, k, v);
            else if (pick < 72)
                send_item(lphm_pkg::OP_LOOKUP, k, $urandom);
            else if (pick < 84)
                send_item(lphm_pkg::OP_ENTER, k, 32'h0);
            else if (pick < 92)
                send_item(2'($urandom_range(0, 1)), $urandom, v);
            else if (pick < 94)
                send_item(lphm_pkg::OP_CLEAR, $urandom, $urandom);
            else if (pick < 96)
                send_item(OP_UNUSED, k, v);
            else
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
        end
    endtask

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        quiet_tail       = 1'b0;
        shadow_live      = 0;
        for (int i = 0; i < SLOTS; i++)
            shadow_used[i] = 1'b0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_opcode      <= lphm_pkg::OP_LOOKUP;
        s_key_id      <= 32'h0;
        s_entry_value <= 32'h0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_full_table();
        test_random_traffic(95);

        wait_results_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lphm_pkg.sv
rtl/core/linear_probe_hash_map_unit.sv
sim/linear_probe_hash_map_unit_tb.sv
